// ===== hw/rtl/lsh_pkg.sv =====
// lsh_pkg: shared types and constants for the latency statistics histogram table
// no dependencies
package lsh_pkg;

  localparam int unsigned SlotW    = 10;
  localparam int unsigned Slots    = 1024;
  localparam int unsigned Buckets  = 33;
  localparam int unsigned BktW     = 6;
  localparam int unsigned BktAddrW = 16;

  typedef enum logic [2:0] {
    CMD_SPAN  = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_SET   = 3'd2,
    CMD_MARK  = 3'd3,
    CMD_DONE  = 3'd4,
    CMD_READS = 3'd5,
    CMD_READH = 3'd6,
    CMD_NONE  = 3'd7
  } cmd_e;

  localparam logic [1:0] KIND_GAUGE  = 2'd1;
  localparam logic [1:0] KIND_VALUES = 2'd2;

  typedef struct packed {
    logic [2:0]       command;
    logic [SlotW-1:0] slot;
    logic [31:0]      sample;
    logic [63:0]      now_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] count;
    logic [63:0] total;
    logic [31:0] maximum;
    logic [31:0] latest;
    logic [5:0]  bucket_index;
    logic [63:0] bucket_count;
    logic [31:0] span_end;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [63:0] count;
    logic [63:0] total;
    logic [31:0] maximum;
    logic [31:0] latest;
    logic [1:0]  kind;
    logic        mark_valid;
    logic [63:0] mark_time;
  } slot_t;

endpackage

// ===== hw/rtl/lsh_if.sv =====
// lsh_in_if / lsh_out_if: valid/ready channels for items and results
// depends on lsh_pkg
interface lsh_in_if;
  logic valid;
  logic ready;
  lsh_pkg::in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lsh_out_if;
  logic valid;
  logic ready;
  lsh_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/latency_stats_histogram_table_top.sv =====
// latency_stats_histogram_table_top: slot statistics table with log2 histograms
// depends on lsh_pkg, lsh_if, lsh_bitlen
// After reset the block sweeps both memories, one slot and one bucket per cycle,
// until the last bucket is cleared (the bucket memory is the larger), before it
// takes the first item. One item is handled at a time and the input is not ready
// meanwhile. Add, set and a done that closes a mark pass through slot read,
// compute, slot write, bucket read and bucket write; mark and a done without a mark
// end after the slot write step, and a none command after the slot read. Span
// records now_time minus sample in slot and histogram, then returns a result; a
// summary read returns the slot after read and compute. A histogram read scans all
// 33 buckets downward through the single bucket read port, then sends one result at
// a time from bucket 0 up to the top nonzero one (bucket 0 if all are zero). Results
// wait in one output register and the input stays blocked until it drains.
module latency_stats_histogram_table_top (
  input logic clk_i,
  input logic rst_ni,
  lsh_in_if.sink   in_i,
  lsh_out_if.source out_o
);
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_CALC, ST_BRD, ST_BCALC, ST_BWR,
    ST_HSCAN, ST_HWAIT, ST_HOUT, ST_HNEXT, ST_OUT
  } state_e;

  state_e state_q;
  lsh_pkg::in_t  item_q;
  lsh_pkg::cmd_e cmd;
  lsh_pkg::slot_t slot_mem [lsh_pkg::Slots];
  logic [63:0] bkt_mem [lsh_pkg::Slots * lsh_pkg::Buckets];
  lsh_pkg::slot_t srd_q;
  lsh_pkg::slot_t slot_d;
  logic        slot_we;
  logic [63:0] brd_q;
  logic [lsh_pkg::BktAddrW-1:0] clr_q;
  logic [lsh_pkg::BktW-1:0] bidx_q, top_q;
  logic        found_q;
  logic [31:0] val_q;
  logic        rec_q;
  lsh_pkg::out_t out_q;
  lsh_pkg::out_t span_res, sum_res, hist_res;
  logic        ovalid_q;
  logic [lsh_pkg::BktW-1:0] vlen;
  logic [lsh_pkg::BktAddrW-1:0] bbase, baddr;
  logic [63:0] dur;
  logic [31:0] span_v;

  lsh_bitlen u_bitlen (.value_i(val_q), .len_o(vlen));

  assign cmd    = lsh_pkg::cmd_e'(item_q.command);
  assign bbase  = 16'(item_q.slot) * 16'(lsh_pkg::Buckets);
  assign baddr  = bbase + 16'(bidx_q);
  assign dur    = item_q.now_time - srd_q.mark_time;
  assign span_v = item_q.now_time[31:0] - item_q.sample;

  assign in_i.ready    = (state_q == ST_IDLE) && !ovalid_q;
  assign out_o.valid   = ovalid_q;
  assign out_o.payload = out_q;

  // slot update applied on the read copy before write-back
  always_comb begin
    slot_d  = srd_q;
    slot_we = 1'b0;
    if (rec_q) begin
      slot_we      = 1'b1;
      slot_d.count = srd_q.count + 64'd1;
      slot_d.total = srd_q.total + 64'(val_q);
      slot_d.latest = val_q;
      if (val_q > srd_q.maximum) slot_d.maximum = val_q;
      if (cmd == lsh_pkg::CMD_ADD) slot_d.kind = lsh_pkg::KIND_VALUES;
      if (cmd == lsh_pkg::CMD_SET) slot_d.kind = lsh_pkg::KIND_GAUGE;
      if (cmd == lsh_pkg::CMD_DONE) slot_d.mark_valid = 1'b0;
    end else if (cmd == lsh_pkg::CMD_MARK && !srd_q.mark_valid) begin
      slot_we           = 1'b1;
      slot_d.mark_valid = 1'b1;
      slot_d.mark_time  = item_q.now_time;
    end
  end

  always_comb begin
    span_res = '0;
    span_res.span_end    = item_q.now_time[31:0];
    span_res.last_of_run = 1'b1;
    sum_res = '0;
    sum_res.kind        = srd_q.kind;
    sum_res.count       = srd_q.count;
    sum_res.total       = srd_q.total;
    sum_res.maximum     = srd_q.maximum;
    sum_res.latest      = srd_q.latest;
    sum_res.last_of_run = 1'b1;
    hist_res = '0;
    hist_res.bucket_index = bidx_q;
    hist_res.bucket_count = brd_q;
    hist_res.last_of_run  = (bidx_q == top_q);
  end

  // memories, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      bkt_mem[clr_q] <= '0;
      if (clr_q < 16'(lsh_pkg::Slots)) slot_mem[clr_q[lsh_pkg::SlotW-1:0]] <= '0;
    end else begin
      if (state_q == ST_BRD && slot_we) slot_mem[item_q.slot] <= slot_d;
      if (state_q == ST_BWR) bkt_mem[baddr] <= brd_q + 64'd1;
    end
    if (state_q == ST_RD) srd_q <= slot_mem[item_q.slot];
    brd_q <= bkt_mem[baddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      item_q   <= '0;
      bidx_q   <= '0;
      top_q    <= '0;
      found_q  <= 1'b0;
      val_q    <= '0;
      rec_q    <= 1'b0;
      out_q    <= '0;
    end else begin
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 16'd1;
          if (clr_q == 16'(lsh_pkg::Slots * lsh_pkg::Buckets - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_i.valid && in_i.ready) begin
            item_q  <= in_i.payload;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          case (cmd)
            lsh_pkg::CMD_READH: begin
              bidx_q  <= 6'(lsh_pkg::Buckets - 1);
              found_q <= 1'b0;
              top_q   <= '0;
              state_q <= ST_HSCAN;
            end
            lsh_pkg::CMD_NONE: state_q <= ST_IDLE;
            default: state_q <= ST_CALC;
          endcase
        end
        ST_CALC: begin
          case (cmd)
            lsh_pkg::CMD_SPAN: begin
              val_q   <= span_v;
              rec_q   <= 1'b1;
              out_q   <= span_res;
              state_q <= ST_BRD;
            end
            lsh_pkg::CMD_ADD, lsh_pkg::CMD_SET: begin
              val_q   <= item_q.sample;
              rec_q   <= 1'b1;
              out_q   <= '0;
              state_q <= ST_BRD;
            end
            lsh_pkg::CMD_DONE: begin
              val_q   <= (dur > 64'hffff_ffff) ? 32'hffff_ffff : dur[31:0];
              rec_q   <= srd_q.mark_valid;
              out_q   <= '0;
              state_q <= ST_BRD;
            end
            lsh_pkg::CMD_READS: begin
              rec_q   <= 1'b0;
              out_q   <= sum_res;
              state_q <= ST_OUT;
            end
            default: begin
              rec_q   <= 1'b0;
              out_q   <= '0;
              state_q <= ST_BRD;
            end
          endcase
        end
        ST_BRD: begin
          if (rec_q) begin
            bidx_q  <= vlen;
            state_q <= ST_BCALC;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        // bucket read lands in brd_q, written back plus one next cycle
        ST_BCALC: state_q <= ST_BWR;
        ST_BWR: state_q <= out_q.last_of_run ? ST_OUT : ST_IDLE;
        ST_HSCAN: state_q <= ST_HWAIT;
        ST_HWAIT: begin
          if (!found_q && (brd_q != '0 || bidx_q == '0)) begin
            found_q <= 1'b1;
            top_q   <= bidx_q;
          end
          if (bidx_q == '0) begin
            state_q <= ST_HNEXT;
          end else begin
            bidx_q  <= bidx_q - 6'd1;
            state_q <= ST_HSCAN;
          end
        end
        ST_HNEXT: state_q <= ST_HOUT;
        ST_HOUT: begin
          if (!ovalid_q) begin
            out_q    <= hist_res;
            ovalid_q <= 1'b1;
            if (bidx_q == top_q) state_q <= ST_IDLE;
            else begin
              bidx_q  <= bidx_q + 6'd1;
              state_q <= ST_HNEXT;
            end
          end
        end
        ST_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.payload))
    else $error("result dropped");
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOUT |-> top_q < 6'(lsh_pkg::Buckets)) else $error("bad top");
endmodule

// ===== hw/rtl/lsh_bitlen.sv =====
// lsh_bitlen: bit length of a 32-bit value, capped to the top bucket
// depends on lsh_pkg
module lsh_bitlen (
  input  logic [31:0] value_i,
  output logic [5:0]  len_o
);
  always_comb begin
    len_o = '0;
    for (int k = 0; k < 32; k++) begin
      if (value_i[k]) len_o = 6'(k + 1);
    end
    if (len_o > 6'(lsh_pkg::Buckets - 1)) len_o = 6'(lsh_pkg::Buckets - 1);
  end
endmodule
